// ----- rtl/plpr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package plpr_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned WORD_W = 16;

  // sync pair: first byte (either form), then second byte
  localparam logic [BYTE_W-1:0] SYNC_FIRST     = 8'h88;
  localparam logic [BYTE_W-1:0] SYNC_FIRST_ALT = 8'h10;
  localparam logic [BYTE_W-1:0] SYNC_SECOND    = 8'h33;

  localparam logic [BYTE_W-1:0] ACK_BYTE = 8'h81;

  localparam logic [BYTE_W-1:0] CMD_INIT   = 8'h01;
  localparam logic [BYTE_W-1:0] CMD_PRINT  = 8'h02;
  localparam logic [BYTE_W-1:0] CMD_DATA   = 8'h04;
  localparam logic [BYTE_W-1:0] CMD_STATUS = 8'h0F;

  localparam logic [BYTE_W-1:0] ST_CLEAR    = 8'h00;
  localparam logic [BYTE_W-1:0] ST_CSUM_ERR = 8'h01;
  localparam logic [BYTE_W-1:0] ST_PRINTING = 8'h04;
  localparam logic [BYTE_W-1:0] ST_DATA_RDY = 8'h08;

endpackage

`default_nettype wire

// ----- rtl/printer_link_packet_receiver.sv -----
// Path: input word -> input register -> reply register -> reply word on m_tvalid.
// Throughput: one word per cycle unless a reply is stalled; the parser state
// advances in a single pass between the input register and the reply register.
// Reset: rst (synchronous, active high) empties both registers and returns the
// parser to sync hunting with all counters, sums and status cleared.
`timescale 1ns / 1ps
`default_nettype none

module printer_link_packet_receiver (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [plpr_pkg::BYTE_W-1:0] s_tdata,   // [7:0] rx_byte
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [plpr_pkg::BYTE_W-1:0] m_tdata    // [7:0] reply_byte
);
  import plpr_pkg::*;

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic [BYTE_W-1:0] reply;
  logic              advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  plpr_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step_en    (advance),
    .rx_byte    (in_byte),
    .reply_byte (reply)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
    if (advance) begin
      m_tdata <= reply;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/plpr_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module plpr_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step_en,
  input  logic [plpr_pkg::BYTE_W-1:0] rx_byte,
  output logic [plpr_pkg::BYTE_W-1:0] reply_byte
);
  import plpr_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_CMD  = 3'd1,
    PH_COMP = 3'd2,
    PH_LEN  = 3'd3,
    PH_DATA = 3'd4,
    PH_CSUM = 3'd5,
    PH_ACK  = 3'd6
  } phase_t;

  phase_t              phase, phase_next;
  logic [WORD_W-1:0]   position, position_next;
  logic [WORD_W-1:0]   payload_length, payload_length_next;
  logic [WORD_W-1:0]   running_sum, running_sum_next;
  logic [WORD_W-1:0]   sent_checksum, sent_checksum_next;
  logic [BYTE_W-1:0]   pending_command, pending_command_next;
  logic [BYTE_W-1:0]   status_byte, status_byte_next;
  logic [BYTE_W-1:0]   previous_byte;
  logic                data_pending, data_pending_next;

  logic [WORD_W-1:0]   pos_inc;
  logic [WORD_W-1:0]   sum_add;
  logic [WORD_W-1:0]   len_full;
  logic [WORD_W-1:0]   chk_full;
  logic                resync;
  logic                cmd_known;
  logic                dp_data;

  assign pos_inc  = position + WORD_W'(1);
  assign sum_add  = running_sum + {{(WORD_W-BYTE_W){1'b0}}, rx_byte};
  assign len_full = {payload_length[WORD_W-1:BYTE_W] | rx_byte, payload_length[BYTE_W-1:0]};
  assign chk_full = {sent_checksum[WORD_W-1:BYTE_W] | rx_byte, sent_checksum[BYTE_W-1:0]};
  assign resync   = (previous_byte == SYNC_FIRST || previous_byte == SYNC_FIRST_ALT) &&
                    (rx_byte == SYNC_SECOND) && (position <= WORD_W'(6));
  assign cmd_known = rx_byte == CMD_INIT || rx_byte == CMD_PRINT ||
                     rx_byte == CMD_DATA || rx_byte == CMD_STATUS ||
                     rx_byte == SYNC_FIRST || rx_byte == SYNC_FIRST_ALT;
  assign dp_data  = data_pending || (payload_length != '0);

  always_comb begin
    phase_next           = phase;
    position_next        = position;
    payload_length_next  = payload_length;
    running_sum_next     = running_sum;
    sent_checksum_next   = sent_checksum;
    pending_command_next = pending_command;
    status_byte_next     = status_byte;
    data_pending_next    = data_pending;
    reply_byte           = '0;

    if (resync) begin
      phase_next       = PH_CMD;
      position_next    = WORD_W'(2);
      running_sum_next = '0;
    end else begin
      case (phase)
        PH_CMD: begin
          pending_command_next = rx_byte;
          running_sum_next     = sum_add;
          if (cmd_known) begin
            phase_next    = PH_COMP;
            position_next = WORD_W'(3);
          end else begin
            // unknown command: drop the packet
            phase_next    = PH_HUNT;
            position_next = '0;
          end
        end
        PH_COMP: begin
          position_next    = pos_inc;
          running_sum_next = sum_add;
          phase_next       = PH_LEN;
        end
        PH_LEN: begin
          position_next    = pos_inc;
          running_sum_next = sum_add;
          if (pos_inc == WORD_W'(5)) begin
            payload_length_next = {{(WORD_W-BYTE_W){1'b0}}, rx_byte};
          end else if (pos_inc == WORD_W'(6)) begin
            position_next       = '0;
            payload_length_next = len_full;
            phase_next          = (len_full != '0) ? PH_DATA : PH_CSUM;
          end
        end
        PH_DATA: begin
          position_next    = pos_inc;
          running_sum_next = sum_add;
          if (pos_inc == payload_length) begin
            position_next = '0;
            phase_next    = PH_CSUM;
          end
        end
        PH_CSUM: begin
          position_next = pos_inc;
          if (pos_inc == WORD_W'(1)) begin
            sent_checksum_next = {{(WORD_W-BYTE_W){1'b0}}, rx_byte};
          end else if (pos_inc == WORD_W'(2)) begin
            position_next      = '0;
            sent_checksum_next = chk_full;
            phase_next         = PH_ACK;
            if (running_sum != chk_full) begin
              status_byte_next = status_byte | ST_CSUM_ERR;
            end else begin
              status_byte_next = status_byte & ~ST_CSUM_ERR;
            end
          end
        end
        PH_ACK: begin
          if (rx_byte == '0) begin
            if (pos_inc == WORD_W'(1)) begin
              position_next = pos_inc;
              reply_byte    = ACK_BYTE;
            end else begin
              position_next    = '0;
              running_sum_next = '0;
              phase_next       = PH_HUNT;
              reply_byte       = status_byte;
              case (pending_command)
                CMD_INIT: begin
                  status_byte_next  = ST_CLEAR;
                  data_pending_next = 1'b0;
                  reply_byte        = ST_CLEAR;
                end
                CMD_PRINT: begin
                  status_byte_next  = ST_PRINTING;
                  data_pending_next = 1'b0;
                  reply_byte        = ST_PRINTING;
                end
                CMD_DATA: begin
                  data_pending_next = dp_data;
                  if (dp_data) begin
                    status_byte_next = ST_DATA_RDY;
                    reply_byte       = ST_DATA_RDY;
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end
        default: begin
          // hunting: hold the word as a possible first sync byte
          phase_next    = PH_HUNT;
          position_next = WORD_W'(1);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      position        <= '0;
      payload_length  <= '0;
      running_sum     <= '0;
      sent_checksum   <= '0;
      pending_command <= '0;
      status_byte     <= '0;
      previous_byte   <= '0;
      data_pending    <= 1'b0;
    end else if (step_en) begin
      phase           <= phase_next;
      position        <= position_next;
      payload_length  <= payload_length_next;
      running_sum     <= running_sum_next;
      sent_checksum   <= sent_checksum_next;
      pending_command <= pending_command_next;
      status_byte     <= status_byte_next;
      previous_byte   <= rx_byte;
      data_pending    <= data_pending_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/plpr_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module plpr_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [plpr_pkg::BYTE_W-1:0] m_tdata
);
  import plpr_pkg::*;

  logic s_take;
  assign s_take = s_tvalid && s_tready;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("reply word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("reply word changed while stalled");

  a_reply_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata == ST_CLEAR || m_tdata == ACK_BYTE ||
                 m_tdata == ST_CSUM_ERR || m_tdata == ST_PRINTING ||
                 m_tdata == (ST_PRINTING | ST_CSUM_ERR) || m_tdata == ST_DATA_RDY ||
                 m_tdata == (ST_DATA_RDY | ST_CSUM_ERR))
    else $error("reply word is neither zero, acknowledge nor a status value");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("reply valid right after reset");

  // a reply needs a word taken in this cycle or the one before
  a_no_reply_without_input: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid && !s_take && !$past(s_take) |=> !m_tvalid)
    else $error("reply appeared with no word pending");

endmodule

bind printer_link_packet_receiver plpr_checker u_plpr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
